[hw/rtl/posix_to_fat_timestamp_defines.svh]
// ----------------------------------------------------------------------------
// posix_to_fat_timestamp_defines.svh
// Assertion macros for the timestamp converter RTL.
// ----------------------------------------------------------------------------
`ifndef POSIX_TO_FAT_TIMESTAMP_DEFINES_SVH
`define POSIX_TO_FAT_TIMESTAMP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define PTF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check a condition whenever the output register holds an item.
`define PTF_ASSERT_OUT(name, cond, msg) \
  `PTF_ASSERT(name, out_if.valid |-> (cond), msg)

`endif

[hw/rtl/ptf_pkg.sv]
// ----------------------------------------------------------------------------
// ptf_pkg
// Types, constants and calendar tables of the timestamp converter.
// ----------------------------------------------------------------------------
package ptf_pkg;

  typedef struct packed {
    logic [31:0] posix_seconds;
  } ptf_item_t;

  typedef struct packed {
    logic [6:0]  year_offset;
    logic [3:0]  month_number;
    logic [4:0]  day_of_month;
    logic [4:0]  hour_of_day;
    logic [5:0]  minute_of_hour;
    logic [5:0]  second_of_minute;
    logic [15:0] fat_time_word;
    logic [15:0] fat_date_word;
    logic        before_1980;
  } ptf_result_t;

  typedef struct packed {
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } ptf_adv_t;

  // seconds / 86400 = (seconds >> 7) / 675
  localparam int unsigned DayShift    = 7;
  localparam int unsigned DayOdd      = 675;
  localparam int unsigned DayMul      = 50903317;
  localparam int unsigned DayMulShift = 35;

  // first day of 2100-03-01 counted from 1970-01-01
  localparam int unsigned LeapSkipDay = 47541;
  // days from 1968-01-01 to 1970-01-01
  localparam int unsigned EpochBias   = 731;
  localparam int unsigned QuadDays    = 1461;
  localparam int unsigned QuadMul     = 91868;
  localparam int unsigned QuadShift   = 27;
  // years from 1968 to 1980
  localparam int unsigned FatYearBias = 12;

  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned HourMul     = 9321;
  localparam int unsigned HourShift   = 21;
  localparam int unsigned SecsPerMin  = 60;
  localparam int unsigned MinMul      = 1093;
  localparam int unsigned MinShift    = 14;

  function automatic logic [8:0] month_start(input logic [3:0] month, input logic leap);
    logic [8:0] base;
    unique case (month)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + 9'(leap && (month > 4'd2));
  endfunction

  function automatic logic [10:0] quad_year_start(input logic [1:0] year_in_quad);
    logic [10:0] base;
    unique case (year_in_quad)
      2'd0:    base = 11'd0;
      2'd1:    base = 11'd366;
      2'd2:    base = 11'd731;
      default: base = 11'd1096;
    endcase
    return base;
  endfunction

endpackage

[hw/rtl/ptf_in_if.sv]
// ----------------------------------------------------------------------------
// ptf_in_if
// Input channel: one POSIX seconds count per item.
// ----------------------------------------------------------------------------
interface ptf_in_if;
  import ptf_pkg::*;

  logic      valid;
  logic      ready;
  ptf_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/ptf_out_if.sv]
// ----------------------------------------------------------------------------
// ptf_out_if
// Output channel: one calendar and FAT timestamp result per item.
// ----------------------------------------------------------------------------
interface ptf_out_if;
  import ptf_pkg::*;

  logic        valid;
  logic        ready;
  ptf_result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/ptf_tod_path.sv]
// ----------------------------------------------------------------------------
// ptf_tod_path
// Time-of-day split of the seconds within a day, stages three to six.
// ----------------------------------------------------------------------------
module ptf_tod_path (
  input  logic              clk_i,
  input  ptf_pkg::ptf_adv_t adv_i,
  input  logic [16:0]       rem_i,
  output logic [4:0]        hour_o,
  output logic [5:0]        minute_o,
  output logic [5:0]        second_o
);
  import ptf_pkg::*;

  logic [26:0] hp3_q, hp3_d;
  logic [16:0] rem3_q;
  logic [4:0]  hour4_d, hour4_q, hour5_q, hour6_q;
  logic [11:0] remh4_d, remh4_q, remh5_q;
  logic [20:0] mp5_d, mp5_q;
  logic [5:0]  minute6_d, minute6_q, second6_d, second6_q;

  assign hp3_d     = 27'(rem_i[16:4]) * 27'(HourMul);
  assign hour4_d   = hp3_q[HourShift+4:HourShift];
  assign remh4_d   = 12'(rem3_q - 17'(hour4_d) * 17'(SecsPerHour));
  assign mp5_d     = 21'(remh4_q[11:2]) * 21'(MinMul);
  assign minute6_d = mp5_q[MinShift+5:MinShift];
  assign second6_d = 6'(remh5_q - 12'(minute6_d) * 12'(SecsPerMin));

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      hp3_q  <= hp3_d;
      rem3_q <= rem_i;
    end
    if (adv_i.s4) begin
      hour4_q <= hour4_d;
      remh4_q <= remh4_d;
    end
    if (adv_i.s5) begin
      hour5_q <= hour4_q;
      remh5_q <= remh4_q;
      mp5_q   <= mp5_d;
    end
    if (adv_i.s6) begin
      hour6_q   <= hour5_q;
      minute6_q <= minute6_d;
      second6_q <= second6_d;
    end
  end

  assign hour_o   = hour6_q;
  assign minute_o = minute6_q;
  assign second_o = second6_q;
endmodule

[hw/rtl/posix_to_fat_timestamp.sv]
// Latency: six register stages lie between an accepted item and its result.
// Throughput: one item per cycle while the output is not stalled, through the six-stage divide-by-constant pipeline.
// Each stage holds while the stage after it is full and stalled, so bubbles collapse.
// Reset (rst_ni low, asynchronous) clears the stage valid bits only.
// ----------------------------------------------------------------------------
// posix_to_fat_timestamp
// Converts a POSIX seconds count to calendar fields and FAT date/time words.
// ----------------------------------------------------------------------------
`include "posix_to_fat_timestamp_defines.svh"

module posix_to_fat_timestamp (
  input logic      clk_i,
  input logic      rst_ni,
  ptf_in_if.sink   in_if,
  ptf_out_if.source out_if
);
  import ptf_pkg::*;

  localparam int unsigned NumStages = 6;

  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;
  ptf_adv_t             adv;

  // stage 1
  logic [50:0] p1_q, p1_d;
  logic [24:0] hi1_q;
  logic [6:0]  lo1_q;
  // stage 2
  logic [15:0] days2_d, days2_q;
  logic [9:0]  remhi2_d;
  logic [16:0] rem2_q;
  // stage 3
  logic [15:0] e3_d, e3_q;
  logic [32:0] qp3_q;
  // stage 4
  logic [5:0]  quad4_d, quad4_q;
  logic [10:0] r4_d, r4_q;
  // stage 5
  logic [1:0]  yi5;
  logic [7:0]  yrel5;
  logic [8:0]  doy5_d, doy5_q;
  logic        leap5_q;
  logic [6:0]  yoff5_q;
  logic        before5_q;
  // stage 6
  logic [10:0] ge6;
  logic [3:0]  month6_d, month6_q;
  logic [4:0]  day6_d, day6_q;
  logic [6:0]  yoff6_q;
  logic        before6_q;

  logic [4:0]  hour;
  logic [5:0]  minute, second;

  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || out_if.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_if.ready = en[0];
  assign adv = '{s3: en[2], s4: en[3], s5: en[4], s6: en[5]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_if.valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign p1_d     = 51'(in_if.payload.posix_seconds[31:DayShift]) * 51'(DayMul);
  assign days2_d  = p1_q[DayMulShift+15:DayMulShift];
  assign remhi2_d = 10'(hi1_q - 25'(days2_d) * 25'(DayOdd));
  assign e3_d     = 16'(days2_q + 16'(days2_q >= 16'(LeapSkipDay)) + 16'(EpochBias));
  assign quad4_d  = qp3_q[QuadShift+5:QuadShift];
  assign r4_d     = 11'(e3_q - 16'(quad4_d) * 16'(QuadDays));

  always_comb begin
    if (r4_q < 11'd366) begin
      yi5 = 2'd0;
    end else if (r4_q < 11'd731) begin
      yi5 = 2'd1;
    end else if (r4_q < 11'd1096) begin
      yi5 = 2'd2;
    end else begin
      yi5 = 2'd3;
    end
  end

  assign doy5_d = 9'(r4_q - quad_year_start(yi5));
  assign yrel5  = {quad4_q, 2'b00} + 8'(yi5);

  always_comb begin
    for (int m = 2; m <= 12; m++) begin
      ge6[m-2] = doy5_q >= month_start(4'(m), leap5_q);
    end
  end

  assign month6_d = 4'd1 + 4'($countones(ge6));
  assign day6_d   = 5'(doy5_q - month_start(month6_d, leap5_q) + 9'd1);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p1_q  <= p1_d;
      hi1_q <= in_if.payload.posix_seconds[31:DayShift];
      lo1_q <= in_if.payload.posix_seconds[DayShift-1:0];
    end
    if (en[1]) begin
      days2_q <= days2_d;
      rem2_q  <= {remhi2_d, lo1_q};
    end
    if (en[2]) begin
      e3_q  <= e3_d;
      qp3_q <= 33'(e3_d) * 33'(QuadMul);
    end
    if (en[3]) begin
      quad4_q <= quad4_d;
      r4_q    <= r4_d;
    end
    if (en[4]) begin
      doy5_q    <= doy5_d;
      leap5_q   <= (yi5 == 2'd0);
      yoff5_q   <= 7'(yrel5 - 8'(FatYearBias));
      before5_q <= yrel5 < 8'(FatYearBias);
    end
    if (en[5]) begin
      month6_q  <= month6_d;
      day6_q    <= day6_d;
      yoff6_q   <= yoff5_q;
      before6_q <= before5_q;
    end
  end

  ptf_tod_path u_tod (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .rem_i    (rem2_q),
    .hour_o   (hour),
    .minute_o (minute),
    .second_o (second)
  );

  assign out_if.valid                    = v_q[NumStages-1];
  assign out_if.payload.year_offset      = yoff6_q;
  assign out_if.payload.month_number     = month6_q;
  assign out_if.payload.day_of_month     = day6_q;
  assign out_if.payload.hour_of_day      = hour;
  assign out_if.payload.minute_of_hour   = minute;
  assign out_if.payload.second_of_minute = second;
  assign out_if.payload.fat_time_word    = {hour, minute, second[5:1]};
  assign out_if.payload.fat_date_word    = {yoff6_q, month6_q, day6_q};
  assign out_if.payload.before_1980      = before6_q;

  `PTF_ASSERT(a_full_stall, (&v_q && !out_if.ready) |-> !in_if.ready, "input taken when full")
  `PTF_ASSERT_OUT(a_date_range, month6_q >= 4'd1 && month6_q <= 4'd12 && day6_q != 5'd0, "bad date")
  `PTF_ASSERT_OUT(a_time_range, hour < 5'd24 && minute < 6'd60 && second < 6'd60, "bad time")
  `PTF_ASSERT_OUT(a_before_year, !before6_q || yoff6_q >= 7'd118, "pre-1980 flag off")
endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Feeds POSIX second counts to the FAT timestamp converter through its
// valid/ready channels and checks every calendar field and both packed words
// in order. A directed table covers the epoch, the 1980 boundary, leap days,
// the 2100 non-leap skip and the top of the 32-bit range. Random items then
// cluster around day, month and year boundaries, with bursty input and a
// stalling output.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import ptf_pkg::*;

  localparam int unsigned RandomItems    = 900;
  localparam int unsigned HoldOffCycles  = 400;
  localparam int unsigned HoldOffAfter   = 400;
  localparam int unsigned DrainCycles    = 20;
  localparam int unsigned CycleLimit     = 200000;
  localparam int unsigned ReportLimit    = 10;
  localparam int unsigned SecsPerDay     = 86400;

  typedef struct {
    logic [31:0] seconds;
    bit          typed;
    ptf_result_t stamp;
  } stim_row_t;

  localparam int unsigned DirectedRows = 18;

  logic clk_i;
  logic rst_ni;

  ptf_in_if  in_ch ();
  ptf_out_if out_ch ();

  posix_to_fat_timestamp uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  ptf_result_t expected_stamps[$];
  int unsigned accepted_items = 0;
  int unsigned error_count    = 0;
  int unsigned cycle_count    = 0;

  stim_row_t directed_rows [DirectedRows] = '{
    '{32'd0, 1'b1, '{7'd118, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 16'h0000, 16'hEC21, 1'b1}},
    '{32'd1, 1'b0, '0},
    '{32'd59, 1'b0, '0},
    '{32'd86399, 1'b0, '0},
    '{32'd86400, 1'b0, '0},
    '{32'd68169600, 1'b0, '0},
    '{32'd94694399, 1'b0, '0},
    '{32'd315532799, 1'b1,
      '{7'd127, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 16'hBF7D, 16'hFF9F, 1'b1}},
    '{32'd315532800, 1'b1, '{7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 16'h0000, 16'h0021, 1'b0}},
    '{32'd951782400, 1'b0, '0},
    '{32'd951868800, 1'b0, '0},
    '{32'd2147483647, 1'b0, '0},
    '{32'd2147483648, 1'b0, '0},
    '{32'd4107542399, 1'b0, '0},
    '{32'd4107542400, 1'b0, '0},
    '{32'hFFFF_FFFF, 1'b1,
      '{7'd126, 4'd2, 5'd7, 5'd6, 6'd28, 6'd15, 16'h3387, 16'hFC47, 1'b0}},
    '{32'hAAAA_AAAA, 1'b0, '0},
    '{32'h5555_5555, 1'b0, '0}
  };

  function automatic bit gregorian_leap(int unsigned yr);
    if ((yr % 4) != 0) return 1'b0;
    if ((yr % 100) != 0) return 1'b1;
    return (yr % 400) == 0;
  endfunction

  function automatic int unsigned days_in_month(int unsigned yr, int unsigned mon);
    case (mon)
      4, 6, 9, 11: return 30;
      2:           return gregorian_leap(yr) ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  function automatic int unsigned first_day_of(int unsigned yr, int unsigned mon);
    int unsigned days;
    int unsigned y;
    int unsigned m;
    days = 0;
    for (y = 1970; y < yr; y++) days += gregorian_leap(y) ? 366 : 365;
    for (m = 1; m < mon; m++) days += days_in_month(yr, m);
    return days;
  endfunction

  function automatic ptf_result_t fat_stamp_of(logic [31:0] secs);
    int unsigned days;
    int unsigned sec_of_day;
    int unsigned yr;
    int unsigned mon;
    int unsigned ylen;
    int unsigned mlen;
    int unsigned hr;
    int unsigned mi;
    int unsigned se;
    ptf_result_t r;
    days       = secs / SecsPerDay;
    sec_of_day = secs % SecsPerDay;
    yr         = 1970;
    forever begin
      ylen = gregorian_leap(yr) ? 366 : 365;
      if (days < ylen) break;
      days -= ylen;
      yr++;
    end
    mon = 1;
    forever begin
      mlen = days_in_month(yr, mon);
      if (days < mlen || mon >= 12) break;
      days -= mlen;
      mon++;
    end
    hr = sec_of_day / 3600;
    mi = (sec_of_day % 3600) / 60;
    se = sec_of_day % 60;
    r.year_offset      = 7'(yr - 1980);
    r.month_number     = 4'(mon);
    r.day_of_month     = 5'(days + 1);
    r.hour_of_day      = 5'(hr);
    r.minute_of_hour   = 6'(mi);
    r.second_of_minute = 6'(se);
    r.fat_time_word    = {r.hour_of_day, r.minute_of_hour, r.second_of_minute[5:1]};
    r.fat_date_word    = {r.year_offset, r.month_number, r.day_of_month};
    r.before_1980      = (yr < 1980);
    return r;
  endfunction

  // cluster around calendar edges; plain 32-bit values keep every bit toggling
  function automatic logic [31:0] random_posix_seconds();
    int unsigned kind;
    int unsigned yr;
    int unsigned mon;
    int unsigned slip;
    longint      t;
    kind = $urandom_range(0, 9);
    slip = $urandom_range(0, 3);
    case (kind)
      0, 1, 2: return $urandom();
      3, 4, 5: begin
        yr  = $urandom_range(1970, 2106);
        mon = $urandom_range(1, 12);
        t   = longint'(first_day_of(yr, mon)) * SecsPerDay;
      end
      6: return $urandom_range(0, 315532799);
      7: t = longint'($urandom_range(0, 49709)) * SecsPerDay;
      8: begin
        yr  = $urandom_range(0, 1) ? 2100 : 2096;
        mon = $urandom_range(2, 3);
        t   = longint'(first_day_of(yr, mon)) * SecsPerDay;
      end
      default: return 32'hFFFF_FFFF - $urandom_range(0, SecsPerDay * 40);
    endcase
    t = $urandom_range(0, 1) ? t + slip : t - 1 - slip;
    if (t < 0 || t > longint'(32'hFFFF_FFFF)) return $urandom();
    return t[31:0];
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : source_side
    int unsigned idx;
    int unsigned burst_left;
    int unsigned gap;
    logic [31:0] secs;
    ptf_result_t stamp;
    rst_ni               <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.payload        <= '0;
    burst_left           = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (idx = 0; idx < DirectedRows + RandomItems; idx++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 48);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
      if (idx < DirectedRows) begin
        secs  = directed_rows[idx].seconds;
        stamp = directed_rows[idx].typed ? directed_rows[idx].stamp : fat_stamp_of(secs);
      end else begin
        secs  = random_posix_seconds();
        stamp = fat_stamp_of(secs);
      end
      in_ch.valid                 <= 1'b1;
      in_ch.payload.posix_seconds <= secs;
      @(posedge clk_i);
      while (!in_ch.ready) @(posedge clk_i);
      expected_stamps.push_back(stamp);
      accepted_items++;
    end
    in_ch.valid <= 1'b0;
    while (expected_stamps.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0 && expected_stamps.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : sink_side
    int unsigned pace_mode;
    int unsigned pace_left;
    int unsigned tick;
    bit          held_off;
    out_ch.ready <= 1'b0;
    held_off     = 1'b0;
    tick         = 0;
    @(posedge rst_ni);
    forever begin
      pace_mode = $urandom_range(0, 3);
      pace_left = $urandom_range(16, 96);
      while (pace_left != 0) begin
        @(posedge clk_i);
        // hold off long enough for the pipeline to fill and stall its input
        if (!held_off && accepted_items >= HoldOffAfter) begin
          held_off     = 1'b1;
          out_ch.ready <= 1'b0;
          repeat (HoldOffCycles) @(posedge clk_i);
        end
        case (pace_mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= (tick % 4) != 3;
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
        tick++;
        pace_left--;
      end
    end
  end

  always @(posedge clk_i) begin
    ptf_result_t got;
    ptf_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      if (expected_stamps.size() == 0) begin
        error_count++;
        if (error_count <= ReportLimit)
          $display("unexpected result at cycle %0d: %p", cycle_count, got);
      end else begin
        want = expected_stamps.pop_front();
        if (got.year_offset !== want.year_offset ||
            got.month_number !== want.month_number ||
            got.day_of_month !== want.day_of_month ||
            got.hour_of_day !== want.hour_of_day ||
            got.minute_of_hour !== want.minute_of_hour ||
            got.second_of_minute !== want.second_of_minute ||
            got.fat_time_word !== want.fat_time_word ||
            got.fat_date_word !== want.fat_date_word ||
            got.before_1980 !== want.before_1980) begin
          error_count++;
          if (error_count <= ReportLimit)
            $display("mismatch at cycle %0d: expected %p actual %p", cycle_count, want, got);
        end
      end
    end
  end

endmodule
